@@ rtl/core/min_max_normalizer_defines.svh @@
// assertion macros used by the normalizer rtl
`ifndef MIN_MAX_NORMALIZER_DEFINES_SVH
`define MIN_MAX_NORMALIZER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk, off during reset
`define MMN_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("min_max_normalizer assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define MMN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("min_max_normalizer assertion failed");

`else

`define MMN_ASSERT_IMPLY(lbl, ante, cons)
`define MMN_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/mmn_pkg.sv @@
package mmn_pkg;

	// pixel format
	localparam int VALUE_BITS    = 24;
	localparam int FRACTION_BITS = 8;
	localparam int TARGET_BITS   = 16;
	localparam int OUT_BITS      = 24;

	// divider sizing: quotient stays below target * 2^FRACTION_BITS
	localparam int QUOT_BITS = TARGET_BITS + FRACTION_BITS;
	localparam int PROD_BITS = VALUE_BITS + TARGET_BITS;
	localparam int DVD_BITS  = VALUE_BITS + QUOT_BITS;
	localparam int CNT_BITS  = $clog2(QUOT_BITS + 1);

	// stream widths, padded to whole bytes
	localparam int S_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
	localparam int M_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	// register map
	localparam int          ADDR_BITS   = 3;
	localparam int          DATA_BITS   = 32;
	localparam logic        REG_TARGET  = 1'b0;
	localparam logic [15:0] TARGET_INIT = 16'd255;

	// request kinds
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_SCALE   = 1'b1;

	// running statistics
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] min_v;
		logic signed [VALUE_BITS-1:0] max_v;
		logic                         have;
	} stat_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/core/mmn_minmax.sv @@
module mmn_minmax (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  upd,
	input  logic                                  first,
	input  logic signed [mmn_pkg::VALUE_BITS-1:0] value,
	output mmn_pkg::stat_t                        stat
);

	logic signed [mmn_pkg::VALUE_BITS-1:0] min_q;
	logic signed [mmn_pkg::VALUE_BITS-1:0] max_q;
	logic                                  have_q;

	// running extremes, restarted by the first flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= {1'b0, {(mmn_pkg::VALUE_BITS-1){1'b1}}};
			max_q  <= {1'b1, {(mmn_pkg::VALUE_BITS-1){1'b0}}};
			have_q <= 1'b0;
		end else if (upd) begin
			have_q <= 1'b1;
			if (first) begin
				min_q <= value;
				max_q <= value;
			end else begin
				if (value < min_q) begin
					min_q <= value;
				end
				if (value > max_q) begin
					max_q <= value;
				end
			end
		end
	end

	assign stat.min_v = min_q;
	assign stat.max_v = max_q;
	assign stat.have  = have_q;

endmodule

@@ rtl/core/mmn_div.sv @@
module mmn_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [mmn_pkg::DVD_BITS-1:0]      dividend,
	input  logic [mmn_pkg::VALUE_BITS-1:0]    divisor,
	output logic [mmn_pkg::QUOT_BITS-1:0]     quotient,
	output mmn_pkg::div_stat_t                stat
);

	localparam int V = mmn_pkg::VALUE_BITS;
	localparam int Q = mmn_pkg::QUOT_BITS;

	logic [V:0]                      rem_q;
	logic [Q-1:0]                    dvd_q;
	logic [V-1:0]                    dsr_q;
	logic [mmn_pkg::CNT_BITS-1:0]    cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [V:0]                      trial;
	logic                            fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q[V-1:0], dvd_q[Q-1]};
		fits  = (trial >= {1'b0, dsr_q});
	end

	// payload: partial remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[mmn_pkg::DVD_BITS-1:Q]};
			dvd_q <= dividend[Q-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
			dvd_q <= {dvd_q[Q-2:0], fits};
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == mmn_pkg::CNT_BITS'(Q - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ rtl/core/min_max_normalizer.sv @@
// Min-max normalizer for signed Q15.8 gray pixels. A measure request (tuser[0] = 0)
// folds its value into the registered running minimum and maximum; tuser[1] set on
// a measure restarts both from that value. A scale request (tuser[0] = 1) returns
// floor((value - min) * scale_target * 256 / (max - min)) in unsigned Q16.8,
// clamped to 0..scale_target*256; with nothing measured or max equal to min the
// result is 0 with tuser set. A scale request passes through a set-up step, a
// multiply step that loads the restoring divider, the divider steps (one quotient
// bit per cycle), a step to take the quotient and the output register; values at or
// outside the measured range, a flat range or nothing measured skip the multiply
// and divider steps. The input is not ready while a scale request is in work, so a
// new request is taken only once the previous scale result has gone to the output
// register; a stalled result holds the input off until the output register frees.
// scale_target is the APB register at address 0 (reset 255); min/max reset to the
// most positive/most negative value.
`include "min_max_normalizer_defines.svh"

module min_max_normalizer (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mmn_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [mmn_pkg::DATA_BITS-1:0]       pwdata,
	output logic [mmn_pkg::DATA_BITS-1:0]       prdata,
	output logic                                pready,
	// request stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mmn_pkg::S_DATA_BITS-1:0]     s_tdata,  // [23:0] value
	input  logic [1:0]                          s_tuser,  // [0] op, [1] first
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mmn_pkg::M_DATA_BITS-1:0]     m_tdata,  // [23:0] scaled_value
	output logic [0:0]                          m_tuser   // [0] range_zero
);

	localparam int V = mmn_pkg::VALUE_BITS;
	localparam int T = mmn_pkg::TARGET_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]                          state_q;
	logic [T-1:0]                        target_q;
	logic signed [V-1:0]                 value_q;
	logic [V-1:0]                        diff_q;
	logic [V-1:0]                        range_q;
	logic [mmn_pkg::OUT_BITS-1:0]        res_q;
	logic                                res_zero_q;
	logic                                m_valid_q;
	logic [mmn_pkg::OUT_BITS-1:0]        m_data_q;
	logic                                m_zero_q;

	logic                                cfg_wr;
	logic                                req_acc;
	logic signed [V-1:0]                 in_value;
	logic                                in_op;
	mmn_pkg::stat_t                      stat;
	mmn_pkg::div_stat_t                  div_stat;
	logic                                div_start;
	logic [mmn_pkg::PROD_BITS-1:0]       product;
	logic [mmn_pkg::DVD_BITS-1:0]        dividend;
	logic [mmn_pkg::QUOT_BITS-1:0]       quotient;
	logic [mmn_pkg::OUT_BITS-1:0]        top_value;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= mmn_pkg::TARGET_INIT;
		end else if (cfg_wr && paddr[2] == mmn_pkg::REG_TARGET) begin
			target_q <= pwdata[T-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == mmn_pkg::REG_TARGET) begin
			prdata = mmn_pkg::DATA_BITS'(target_q);
		end
	end

	// request decode
	assign s_tready = (state_q == ST_IDLE);
	assign req_acc  = s_tvalid & s_tready;
	assign in_value = s_tdata[V-1:0];
	assign in_op    = s_tuser[0];

	mmn_minmax u_minmax (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (req_acc && in_op == mmn_pkg::OP_MEASURE),
		.first  (s_tuser[1]),
		.value  (in_value),
		.stat   (stat)
	);

	// multiply feeds the divider load register directly
	assign product   = mmn_pkg::PROD_BITS'(diff_q) * mmn_pkg::PROD_BITS'(target_q);
	assign dividend  = mmn_pkg::DVD_BITS'(product) << mmn_pkg::FRACTION_BITS;
	assign div_start = (state_q == ST_MUL);
	assign top_value = mmn_pkg::OUT_BITS'(
		mmn_pkg::QUOT_BITS'(target_q) << mmn_pkg::FRACTION_BITS);

	mmn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (range_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// scale datapath registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			value_q <= in_value;
		end
		if (state_q == ST_PREP) begin
			diff_q  <= value_q - stat.min_v;
			range_q <= stat.max_v - stat.min_v;
			if (!stat.have || stat.max_v <= stat.min_v) begin
				res_q      <= '0;
				res_zero_q <= 1'b1;
			end else begin
				res_zero_q <= 1'b0;
				res_q      <= (value_q >= stat.max_v) ? top_value : '0;
			end
		end
		if (state_q == ST_DIV && div_stat.done) begin
			res_q <= mmn_pkg::OUT_BITS'(quotient);
		end
		if (state_q == ST_OUT && (!m_valid_q || m_tready)) begin
			m_data_q <= res_q;
			m_zero_q <= res_zero_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc && in_op == mmn_pkg::OP_SCALE) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (!stat.have || stat.max_v <= stat.min_v
						|| value_q <= stat.min_v || value_q >= stat.max_v) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!m_valid_q || m_tready)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = mmn_pkg::M_DATA_BITS'(m_data_q);
	assign m_tuser[0] = m_zero_q;

	// checks
	`MMN_ASSERT_IMPLY(a_zero_flag_zero_value, m_valid_q && m_zero_q, m_data_q == '0)
	`MMN_ASSERT_IMPLY(a_result_in_range, m_valid_q, m_data_q <= top_value)
	`MMN_ASSERT_IMPLY(a_div_done_in_div, div_stat.done, state_q == ST_DIV)
	`MMN_ASSERT_NEXT(a_scale_blocks_input, req_acc && in_op == mmn_pkg::OP_SCALE, !s_tready)

endmodule
